@@ hdl/rtc3w_pkg.sv @@
package rtc3w_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CfgW = 16;

  // largest half period the counter can hold
  localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_CMD_HIGH = 3'd1;
  localparam logic [2:0] PH_CMD_LOW  = 3'd2;
  localparam logic [2:0] PH_WR_HIGH  = 3'd3;
  localparam logic [2:0] PH_WR_LOW   = 3'd4;
  localparam logic [2:0] PH_RD_HIGH  = 3'd5;
  localparam logic [2:0] PH_RD_LOW   = 3'd6;

  typedef struct packed {
    logic ce;
    logic sclk;
    logic io;
    logic drv;
  } pins_t;

  typedef struct packed {
    logic [2:0]             phase;
    logic [2:0]             bit_index;
    logic [7:0]             tx_shift;
    logic [7:0]             data_hold;
    logic [7:0]             rx_shift;
    logic [COUNT_WIDTH-1:0] wait_count;
    logic                   is_read;
    pins_t                  pins;
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] command_byte;
    logic [7:0] write_byte;
    logic       io_level;
  } item_t;

  typedef struct packed {
    logic       chip_enable;
    logic       serial_clock;
    logic       io_out;
    logic       io_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       rejected;
  } result_t;

  // zero acts as one, oversize saturates to the counter range
  function automatic logic [COUNT_WIDTH-1:0] reload_value(input logic [CfgW-1:0] hpt);
    logic [31:0] v;
    v = 32'(hpt);
    if (v == 32'd0) v = 32'd1;
    if (v > CountMax) v = CountMax;
    return v[COUNT_WIDTH-1:0];
  endfunction

endpackage

@@ hdl/three_wire_rtc_serial_master.sv @@
// Channel  | handshake                    | beat contents
// ---------+------------------------------+---------------------------------------------
// input    | in_valid / in_ready          | action, command_byte, write_byte, io_level
// result   | out_valid / out_ready        | chip_enable .. rejected, one per input beat
// config   | cfg_wr_en (no wait)          | cfg_wr_data = half_period_ticks
//
// One beat per cycle sustained while out_ready stays high: input register, one pass of the step logic, result register.
// Result is valid once the beat moves from the input register into the result register.
// The result register frees the input register whenever out_ready is high or it is empty.
// Reset (rst, synchronous) empties both registers, sets half period to 13 and the lines idle.
// A stall on the result side holds the line state; no tick is lost or counted twice.
module three_wire_rtc_serial_master (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [7:0]  command_byte,
  input  logic [7:0]  write_byte,
  input  logic        io_level,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        chip_enable,
  output logic        serial_clock,
  output logic        io_out,
  output logic        io_drive,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_data,
  output logic        rejected,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import rtc3w_pkg::*;

  logic    [15:0] half_period;
  logic           item_valid;
  item_t          item;
  state_t         st;
  state_t         st_next;
  result_t        res_next;
  result_t        res;
  logic           advance;

  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  rtc3w_step u_step (
    .st          (st),
    .item        (item),
    .half_period (half_period),
    .st_next     (st_next),
    .res         (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= 16'd13;
    end else if (cfg_wr_en) begin
      half_period <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= '{action: action, command_byte: command_byte,
                write_byte: write_byte, io_level: io_level};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.bit_index  <= 3'd0;
      st.tx_shift   <= 8'd0;
      st.data_hold  <= 8'd0;
      st.rx_shift   <= 8'd0;
      st.wait_count <= '0;
      st.is_read    <= 1'b0;
      st.pins       <= '{ce: 1'b0, sclk: 1'b0, io: 1'b0, drv: 1'b1};
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign chip_enable  = res.chip_enable;
  assign serial_clock = res.serial_clock;
  assign io_out       = res.io_out;
  assign io_drive     = res.io_drive;
  assign busy_res     = res.busy_res;
  assign done_res     = res.done_res;
  assign read_data    = res.read_data;
  assign rejected     = res.rejected;

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && done_res) |-> !busy_res)
    else $error("done beat still reports busy");

  a_done_not_rejected: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(done_res && rejected))
    else $error("done and rejected in one beat");

  a_released_pin_low: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !io_drive) |-> !io_out)
    else $error("io_out high while pin released");

  a_state_holds_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("line state moved without a beat");

  a_busy_matches_phase: assert property (@(posedge clk) disable iff (rst)
    advance |=> (busy_res == (st.phase != PH_IDLE)))
    else $error("busy flag disagrees with phase");

endmodule

@@ hdl/rtc3w_step.sv @@
module rtc3w_step (
  input  rtc3w_pkg::state_t     st,
  input  rtc3w_pkg::item_t      item,
  input  logic [15:0]           half_period,
  output rtc3w_pkg::state_t     st_next,
  output rtc3w_pkg::result_t    res
);
  import rtc3w_pkg::*;

  logic       done;
  logic       rej;
  logic [7:0] rd;
  logic [2:0] bi_inc;
  logic [COUNT_WIDTH-1:0] wc_dec;
  logic [COUNT_WIDTH-1:0] reload;

  assign bi_inc = st.bit_index + 3'd1;
  assign wc_dec = st.wait_count - COUNT_WIDTH'(1);
  assign reload = reload_value(half_period);

  always_comb begin
    st_next = st;
    done    = 1'b0;
    rej     = 1'b0;
    rd      = 8'd0;
    if (item.action == ACT_WRITE || item.action == ACT_READ) begin
      if (st.phase != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        st_next.is_read    = (item.action == ACT_READ);
        st_next.tx_shift   = item.command_byte;
        st_next.data_hold  = item.write_byte;
        st_next.rx_shift   = 8'd0;
        st_next.bit_index  = 3'd0;
        st_next.pins       = '{ce: 1'b1, sclk: 1'b1, io: item.command_byte[0], drv: 1'b1};
        st_next.phase      = PH_CMD_HIGH;
        st_next.wait_count = reload;
      end
    end else if (item.action == ACT_TICK && st.phase != PH_IDLE) begin
      st_next.wait_count = wc_dec;
      if (wc_dec == '0) begin
        case (st.phase)
          PH_CMD_HIGH, PH_WR_HIGH, PH_RD_HIGH: begin
            st_next.pins.sclk  = 1'b0;
            st_next.phase      = st.phase + 3'd1;
            st_next.wait_count = reload;
          end
          PH_CMD_LOW, PH_WR_LOW: begin
            if (st.bit_index != 3'd7) begin
              st_next.bit_index  = bi_inc;
              st_next.pins       = '{ce: 1'b1, sclk: 1'b1, io: st.tx_shift[bi_inc], drv: 1'b1};
              st_next.phase      = st.phase - 3'd1;
              st_next.wait_count = reload;
            end else if (st.phase == PH_CMD_LOW) begin
              st_next.bit_index  = 3'd0;
              st_next.wait_count = reload;
              if (st.is_read) begin
                // bit 0 of the read byte is taken before any clock
                st_next.rx_shift = {7'd0, item.io_level};
                st_next.pins     = '{ce: 1'b1, sclk: 1'b1, io: 1'b0, drv: 1'b0};
                st_next.phase    = PH_RD_HIGH;
              end else begin
                st_next.tx_shift = st.data_hold;
                st_next.pins     = '{ce: 1'b1, sclk: 1'b1, io: st.data_hold[0], drv: 1'b1};
                st_next.phase    = PH_WR_HIGH;
              end
            end else begin
              st_next.pins  = '{ce: 1'b0, sclk: 1'b0, io: 1'b0, drv: 1'b1};
              st_next.phase = PH_IDLE;
              done          = 1'b1;
            end
          end
          PH_RD_LOW: begin
            st_next.bit_index = bi_inc;
            st_next.rx_shift  = st.rx_shift | (8'(item.io_level) << bi_inc);
            if (bi_inc == 3'd7) begin
              st_next.pins  = '{ce: 1'b0, sclk: 1'b0, io: 1'b0, drv: 1'b1};
              st_next.phase = PH_IDLE;
              done          = 1'b1;
              rd            = st_next.rx_shift;
            end else begin
              st_next.pins       = '{ce: 1'b1, sclk: 1'b1, io: 1'b0, drv: 1'b0};
              st_next.phase      = PH_RD_HIGH;
              st_next.wait_count = reload;
            end
          end
          default: begin
            st_next.phase = PH_IDLE;
            st_next.pins  = '{ce: 1'b0, sclk: 1'b0, io: 1'b0, drv: 1'b1};
          end
        endcase
      end
    end
  end

  always_comb begin
    res.chip_enable  = st_next.pins.ce;
    res.serial_clock = st_next.pins.sclk;
    res.io_out       = st_next.pins.drv & st_next.pins.io;
    res.io_drive     = st_next.pins.drv;
    res.busy_res     = (st_next.phase != PH_IDLE);
    res.done_res     = done;
    res.read_data    = rd;
    res.rejected     = rej;
  end

endmodule
